[rtl/assert_macros.svh]
// assertion macros used by deadline_slot_timer_table
// clocked on aclk; ASSERT_PROP is disabled while aresetn is low; empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/dstt_pkg.sv]
// shared constants, codes and types of the deadline slot timer table
// no dependencies
`timescale 1ns / 1ps

package dstt_pkg;

    localparam int SLOT_COUNT = 8;
    localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    localparam int TIME_W   = 48;
    localparam int MIN_W    = 20;
    localparam int DELAY_W  = 58;
    localparam int HANDLE_W = 24;
    localparam int GEN_W    = 16;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 3;

    localparam logic [TIME_W-1:0] EPOCH_RESET     = 48'd1672531200000;
    localparam logic [MIN_W-1:0]  MIN_DELAY_RESET = 20'd1000;

    localparam logic CFG_EPOCH     = 1'b0;
    localparam logic CFG_MIN_DELAY = 1'b1;

    localparam logic [CMD_W-1:0] CMD_REGISTER   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ARM        = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CANCEL     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_UNREGISTER = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK       = 3'd4;
    localparam logic [CMD_W-1:0] CMD_TRUST      = 3'd5;
    localparam logic [CMD_W-1:0] CMD_ACK        = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_FREE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_PENDING   = 3'd4;

    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_FIRE  = 1'b1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_EPOCH = 9'b000000010,
        S_CMD   = 9'b000000100,
        S_ALLOC = 9'b000001000,
        S_FIRE  = 9'b000010000,
        S_MIN   = 9'b000100000,
        S_DIFF  = 9'b001000000,
        S_MUL   = 9'b010000000,
        S_REPLY = 9'b100000000
    } state_t;

    typedef struct packed {
        logic              lt;
        logic [TIME_W-1:0] diff;
    } cmp_res_t;

    typedef struct packed {
        logic              gen_we;
        logic [GEN_W-1:0]  gen;
        logic              reg_we;
        logic              reg_val;
        logic              arm_we;
        logic              arm_val;
        logic              pend_we;
        logic              pend_val;
        logic              dl_we;
        logic [TIME_W-1:0] dl;
    } slot_wr_t;

endpackage

[rtl/deadline_slot_timer_table.sv]
// deadline slot timer table top level: slot state, sequencer, output register
// depends on dstt_pkg, dstt_cmp_unit and assert_macros.svh
`timescale 1ns / 1ps
//
//  channel   direction  handshake           payload
//  s_        in         s_valid / s_ready   cmd, handle, deadline_ms, now_ms
//  m_        out        m_valid / m_ready   kind, status, handle_out, timer_armed,
//                                           timer_delay_us, clock_trusted, last
//  cfg_      in         cfg_valid/cfg_ready cfg_index, cfg_data
//
//  a request runs the sequencer through its slot scans; the fire and earliest scans
//  use the shared compare unit, a register first runs a free slot search that stops at
//  the first hit, a tick/trust with a trusted clock adds a fire scan, output stalls hold it
//  s_ready is high only while the sequencer is idle; cfg_ready is always high
//  each fire event and the final reply wait for the output register to be free
//  synchronous active-low reset clears all slots, the trusted flag, state, index and m_valid

`include "assert_macros.svh"

module deadline_slot_timer_table
    import dstt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CMD_W-1:0]    s_cmd,
    input  logic [HANDLE_W-1:0] s_handle,
    input  logic [TIME_W-1:0]   s_deadline_ms,
    input  logic [TIME_W-1:0]   s_now_ms,

    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_kind,
    output logic [STATUS_W-1:0] m_status,
    output logic [HANDLE_W-1:0] m_handle_out,
    output logic                m_timer_armed,
    output logic [DELAY_W-1:0]  m_timer_delay_us,
    output logic                m_clock_trusted,
    output logic                m_last,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [TIME_W-1:0]   cfg_data
);

    state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    logic [CMD_W-1:0]    cmd_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [TIME_W-1:0]   deadline_reg;
    logic [TIME_W-1:0]   now_reg;

    logic [TIME_W-1:0] epoch_reg;
    logic [MIN_W-1:0]  min_delay_reg;

    logic [GEN_W-1:0]      slot_gen_reg [SLOT_COUNT];
    logic [TIME_W-1:0]     slot_dl_reg  [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] slot_registered_reg;
    logic [SLOT_COUNT-1:0] slot_armed_reg;
    logic [SLOT_COUNT-1:0] slot_pending_reg;
    logic                  trusted_flag_reg, trusted_flag_next;

    logic                now_ge_reg, now_ge_next;
    logic                clk_ok_reg, clk_ok_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [HANDLE_W-1:0] hout_reg, hout_next;
    logic [TIME_W-1:0]   earliest_reg, earliest_next;
    logic                found_reg, found_next;
    logic                future_reg, future_next;
    logic [TIME_W-1:0]   diff_reg, diff_next;
    logic [DELAY_W-1:0]  product_reg, product_next;

    logic                m_valid_reg;
    logic                m_kind_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [HANDLE_W-1:0] m_handle_reg;
    logic                m_armed_reg;
    logic [DELAY_W-1:0]  m_delay_reg;
    logic                m_trusted_reg;
    logic                m_last_reg;

    logic                out_free;
    logic                out_load;
    logic                out_kind;
    logic [STATUS_W-1:0] out_status;
    logic [HANDLE_W-1:0] out_slot_handle;
    logic                out_armed;
    logic [DELAY_W-1:0]  out_delay;
    logic                out_clk_ok;
    logic                out_last;

    logic [TIME_W-1:0] cmp_a;
    logic [TIME_W-1:0] cmp_b;
    cmp_res_t          cmp;
    slot_wr_t          wr;

    logic [GEN_W-1:0]  cur_gen;
    logic [TIME_W-1:0] cur_dl;
    logic              cur_registered;
    logic              cur_armed;
    logic              cur_pending;
    logic              idx_last;
    logic [7:0]        h_low;
    logic [GEN_W-1:0]  h_gen;
    logic              low_ok;
    logic              hmatch;
    logic [GEN_W-1:0]  gen_inc;
    logic [HANDLE_W-1:0] cur_handle;
    logic [7:0]        s_low_m1;
    logic [DELAY_W-1:0] diff_ext;
    logic [DELAY_W-1:0] clamped;
    logic              accept;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign s_low_m1  = s_handle[7:0] - 8'd1;

    assign cur_gen        = slot_gen_reg[idx_reg];
    assign cur_dl         = slot_dl_reg[idx_reg];
    assign cur_registered = slot_registered_reg[idx_reg];
    assign cur_armed      = slot_armed_reg[idx_reg];
    assign cur_pending    = slot_pending_reg[idx_reg];
    assign idx_last       = (idx_reg == LAST_IDX);
    assign cur_handle     = {cur_gen, 8'(idx_reg) + 8'd1};

    assign h_low   = handle_reg[7:0];
    assign h_gen   = handle_reg[HANDLE_W-1:8];
    assign low_ok  = (h_low != 8'd0) && (h_low <= 8'(SLOT_COUNT));
    assign hmatch  = low_ok && (h_gen != '0) && (cur_gen == h_gen);
    assign gen_inc = (cur_gen == {GEN_W{1'b1}}) ? GEN_W'(1) : cur_gen + GEN_W'(1);

    assign out_free = !m_valid_reg || m_ready;
    assign diff_ext = {{(DELAY_W-TIME_W){1'b0}}, diff_reg};
    assign clamped  = (!future_reg || product_reg < DELAY_W'(min_delay_reg))
                    ? DELAY_W'(min_delay_reg) : product_reg;

    always_comb begin
        unique case (state_reg)
            S_EPOCH: begin
                cmp_a = now_reg;
                cmp_b = epoch_reg;
            end
            S_FIRE: begin
                cmp_a = now_reg;
                cmp_b = cur_dl;
            end
            S_MIN: begin
                cmp_a = cur_dl;
                cmp_b = earliest_reg;
            end
            default: begin
                cmp_a = now_reg;
                cmp_b = earliest_reg;
            end
        endcase
    end

    dstt_cmp_unit u_cmp (
        .op_a (cmp_a),
        .op_b (cmp_b),
        .res  (cmp)
    );

    always_comb begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        trusted_flag_next = trusted_flag_reg;
        now_ge_next       = now_ge_reg;
        clk_ok_next       = clk_ok_reg;
        status_next       = status_reg;
        hout_next         = hout_reg;
        earliest_next     = earliest_reg;
        found_next        = found_reg;
        future_next       = future_reg;
        diff_next         = diff_reg;
        product_next      = product_reg;
        wr                = '0;
        out_load          = 1'b0;
        out_kind          = KIND_REPLY;
        out_status        = ST_OK;
        out_slot_handle   = '0;
        out_armed         = 1'b0;
        out_delay         = '0;
        out_clk_ok        = 1'b0;
        out_last          = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    idx_next   = s_low_m1[IDX_W-1:0];
                    status_next = ST_OK;
                    hout_next  = '0;
                    state_next = S_EPOCH;
                end
            end
            S_EPOCH: begin
                now_ge_next = !cmp.lt;
                state_next  = S_CMD;
            end
            S_CMD: begin
                clk_ok_next   = trusted_flag_reg && now_ge_reg;
                found_next    = 1'b0;
                earliest_next = '0;
                state_next    = S_MIN;
                idx_next      = '0;
                case (cmd_reg) inside
                    CMD_REGISTER: begin
                        state_next = S_ALLOC;
                    end
                    CMD_ARM: begin
                        if (deadline_reg == '0) begin
                            status_next = ST_INVALID;
                        end else if (!(hmatch && cur_registered)) begin
                            status_next = ST_NOT_FOUND;
                        end else begin
                            wr.dl_we   = 1'b1;
                            wr.dl      = deadline_reg;
                            wr.arm_we  = 1'b1;
                            wr.arm_val = 1'b1;
                        end
                    end
                    CMD_CANCEL: begin
                        if (!(hmatch && cur_registered)) begin
                            status_next = ST_NOT_FOUND;
                        end else begin
                            wr.dl_we  = 1'b1;
                            wr.arm_we = 1'b1;
                        end
                    end
                    CMD_UNREGISTER: begin
                        if (handle_reg == '0) begin
                            status_next = ST_INVALID;
                        end else if (!hmatch) begin
                            status_next = ST_NOT_FOUND;
                        end else begin
                            wr.reg_we   = cur_registered;
                            wr.arm_we   = cur_registered;
                            wr.dl_we    = cur_registered;
                            status_next = cur_pending ? ST_PENDING : ST_OK;
                        end
                    end
                    CMD_TICK, CMD_TRUST: begin
                        if (cmd_reg == CMD_TRUST && now_ge_reg) begin
                            trusted_flag_next = 1'b1;
                        end
                        clk_ok_next = (trusted_flag_reg || (cmd_reg == CMD_TRUST))
                                    && now_ge_reg;
                        if (clk_ok_next) begin
                            state_next = S_FIRE;
                        end
                    end
                    CMD_ACK: begin
                        if (!hmatch) begin
                            status_next = ST_NOT_FOUND;
                        end else begin
                            wr.pend_we = 1'b1;
                        end
                    end
                    default: begin
                        status_next = ST_INVALID;
                    end
                endcase
            end
            S_ALLOC: begin
                if (!cur_registered && !cur_pending) begin
                    wr.gen_we   = 1'b1;
                    wr.gen      = gen_inc;
                    wr.reg_we   = 1'b1;
                    wr.reg_val  = 1'b1;
                    wr.arm_we   = 1'b1;
                    wr.dl_we    = 1'b1;
                    hout_next   = {gen_inc, 8'(idx_reg) + 8'd1};
                    status_next = ST_OK;
                    idx_next    = '0;
                    state_next  = S_MIN;
                end else if (idx_last) begin
                    status_next = ST_NO_FREE;
                    idx_next    = '0;
                    state_next  = S_MIN;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_FIRE: begin
                if (cur_registered && cur_armed && !cmp.lt) begin
                    if (out_free) begin
                        wr.arm_we       = 1'b1;
                        wr.pend_we      = 1'b1;
                        wr.pend_val     = 1'b1;
                        out_load        = 1'b1;
                        out_kind        = KIND_FIRE;
                        out_slot_handle = cur_handle;
                        out_clk_ok      = 1'b1;
                        idx_next        = idx_last ? '0 : idx_reg + IDX_W'(1);
                        state_next      = idx_last ? S_MIN : S_FIRE;
                    end
                end else begin
                    idx_next   = idx_last ? '0 : idx_reg + IDX_W'(1);
                    state_next = idx_last ? S_MIN : S_FIRE;
                end
            end
            S_MIN: begin
                if (cur_registered && cur_armed && (!found_reg || cmp.lt)) begin
                    earliest_next = cur_dl;
                end
                if (cur_registered && cur_armed) begin
                    found_next = 1'b1;
                end
                idx_next   = idx_last ? '0 : idx_reg + IDX_W'(1);
                state_next = idx_last ? S_DIFF : S_MIN;
            end
            S_DIFF: begin
                future_next = cmp.lt;
                diff_next   = cmp.diff;
                state_next  = S_MUL;
            end
            S_MUL: begin
                product_next = (diff_ext << 10) - (diff_ext << 4) - (diff_ext << 3);
                state_next   = S_REPLY;
            end
            S_REPLY: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    out_kind        = KIND_REPLY;
                    out_status      = status_reg;
                    out_slot_handle = hout_reg;
                    out_armed       = clk_ok_reg && found_reg;
                    out_delay       = (clk_ok_reg && found_reg) ? clamped : '0;
                    out_clk_ok      = clk_ok_reg;
                    out_last        = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= S_IDLE;
            idx_reg             <= '0;
            trusted_flag_reg    <= 1'b0;
            slot_registered_reg <= '0;
            slot_armed_reg      <= '0;
            slot_pending_reg    <= '0;
            epoch_reg           <= EPOCH_RESET;
            min_delay_reg       <= MIN_DELAY_RESET;
            m_valid_reg         <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_gen_reg[i] <= '0;
                slot_dl_reg[i]  <= '0;
            end
        end else begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            trusted_flag_reg <= trusted_flag_next;
            if (wr.gen_we) begin
                slot_gen_reg[idx_reg] <= wr.gen;
            end
            if (wr.dl_we) begin
                slot_dl_reg[idx_reg] <= wr.dl;
            end
            if (wr.reg_we) begin
                slot_registered_reg[idx_reg] <= wr.reg_val;
            end
            if (wr.arm_we) begin
                slot_armed_reg[idx_reg] <= wr.arm_val;
            end
            if (wr.pend_we) begin
                slot_pending_reg[idx_reg] <= wr.pend_val;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_EPOCH:     epoch_reg     <= cfg_data;
                    CFG_MIN_DELAY: min_delay_reg <= cfg_data[MIN_W-1:0];
                    default:       epoch_reg     <= epoch_reg;
                endcase
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg      <= s_cmd;
            handle_reg   <= s_handle;
            deadline_reg <= s_deadline_ms;
            now_reg      <= s_now_ms;
        end
        now_ge_reg   <= now_ge_next;
        clk_ok_reg   <= clk_ok_next;
        status_reg   <= status_next;
        hout_reg     <= hout_next;
        earliest_reg <= earliest_next;
        found_reg    <= found_next;
        future_reg   <= future_next;
        diff_reg     <= diff_next;
        product_reg  <= product_next;
        if (out_load) begin
            m_kind_reg    <= out_kind;
            m_status_reg  <= out_status;
            m_handle_reg  <= out_slot_handle;
            m_armed_reg   <= out_armed;
            m_delay_reg   <= out_delay;
            m_trusted_reg <= out_clk_ok;
            m_last_reg    <= out_last;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_kind           = m_kind_reg;
    assign m_status         = m_status_reg;
    assign m_handle_out     = m_handle_reg;
    assign m_timer_armed    = m_armed_reg;
    assign m_timer_delay_us = m_delay_reg;
    assign m_clock_trusted  = m_trusted_reg;
    assign m_last           = m_last_reg;

    `ASSERT_PROP(a_last_is_reply, m_valid |-> (m_last == (m_kind == KIND_REPLY)), "last must mark the reply")
    `ASSERT_PROP(a_fire_trusted, (m_valid && m_kind == KIND_FIRE) |-> (m_clock_trusted && !m_timer_armed), "fire event without trusted clock")
    `ASSERT_PROP(a_armed_registered, (slot_armed_reg & ~slot_registered_reg) == '0, "armed slot not registered")
    `ASSERT_PROP(a_accept_busy, accept |=> (state_reg == S_EPOCH && !s_ready), "sequencer did not start")

endmodule

[rtl/dstt_cmp_unit.sv]
// shared 48-bit compare and subtract unit: lt = a < b, diff = b - a
// depends on dstt_pkg
`timescale 1ns / 1ps

module dstt_cmp_unit
    import dstt_pkg::*;
(
    input  logic [TIME_W-1:0] op_a,
    input  logic [TIME_W-1:0] op_b,
    output cmp_res_t          res
);

    always_comb begin
        res.lt   = op_a < op_b;
        res.diff = op_b - op_a;
    end

endmodule
